// ===== rtl/core/rsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types, register codes and rotor wiring tables for the rotor
// substitution cipher core.
// ----------------------------------------------------------------------------
`default_nettype none

package rsc_pkg;

  localparam int MAX_ROTOR_SLOTS_DEF = 4;
  localparam int SLOT_REGS           = 4;
  localparam int SLOT_IDX_W          = $clog2(SLOT_REGS);
  localparam int LETTERS             = 26;
  localparam int NUM_WIRINGS         = 9;
  localparam int SEL_W               = 4;
  localparam int CNT_W               = 3;
  localparam int ROT_W               = 5;
  localparam int LETTER_W            = 5;
  localparam int CHAR_W              = 8;
  localparam int ADDR_W              = 5;
  localparam int DATA_W              = 32;

  localparam logic [CHAR_W-1:0]   CHAR_A     = 8'h41;
  localparam logic [CHAR_W-1:0]   CHAR_Z     = 8'h5A;
  localparam logic [SEL_W-1:0]    WIRING_MIN = 4'd1;
  localparam logic [SEL_W-1:0]    WIRING_MAX = 4'd8;
  localparam logic [SEL_W-1:0]    WIRING_ID  = 4'd0;
  localparam logic [LETTER_W:0]   LETTERS_W  = 6'd26;

  typedef enum logic [2:0] {
    REG_FIRST_ROTOR   = 3'd0,
    REG_SECOND_ROTOR  = 3'd1,
    REG_THIRD_ROTOR   = 3'd2,
    REG_FOURTH_ROTOR  = 3'd3,
    REG_ACTIVE_ROTORS = 3'd4,
    REG_ROTATION      = 3'd5,
    REG_DECRYPT_MODE  = 3'd6
  } reg_idx_t;

  // settings as seen by the datapath, already normalized
  typedef struct packed {
    logic [SLOT_REGS-1:0][SEL_W-1:0] wiring;
    logic [CNT_W-1:0]                count;
    logic [ROT_W-1:0]                rot;
    logic                            decrypt;
  } cfg_t;

  typedef struct packed {
    logic                letter;
    logic [LETTER_W-1:0] idx;
    logic [CHAR_W-1:0]   code;
  } stage_t;

  // entry zero is the identity wiring
  localparam logic [LETTERS*8-1:0] WIRING [NUM_WIRINGS] = '{
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
    "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
    "AJDKSIRUXBLHWTMCQGZNPYFVOE",
    "BDFHJLCPRTXVZNYEIWGAKMUSQO",
    "ESOVPZJAYQUIRHXLNFTGKDCMWB",
    "VZBRGITYUPSDNHLXAWMJQOFECK",
    "JPGVOUMFYQBENHZRDKASXLICTW",
    "NZJHGRCXMYSWBOUFAIVLPEKQDT",
    "FKQHTLXOCBJSPDZRAMEWNIUYGV"
  };

  function automatic logic [LETTER_W-1:0] wire_out(input logic [SEL_W-1:0] tab,
                                                   input logic [LETTER_W-1:0] pos);
    logic [LETTERS*8-1:0] row;
    logic [CHAR_W-1:0]    ch;
    row = WIRING[tab];
    ch  = row[8*(LETTERS-1-int'(pos)) +: 8];
    return LETTER_W'(ch - CHAR_A);
  endfunction

  // position in the table whose entry equals y
  function automatic logic [LETTER_W-1:0] wire_in(input logic [SEL_W-1:0] tab,
                                                  input logic [LETTER_W-1:0] y);
    logic [LETTER_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < LETTERS; i++) begin
      if (wire_out(tab, LETTER_W'(i)) == y) begin
        pos = LETTER_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rotor_substitution_cipher_core.sv =====
// ----------------------------------------------------------------------------
// rotor_substitution_cipher_core
// Rotor substitution cipher: uppercase letters pass through up to four
// rotated wiring tables, other bytes pass unchanged.
// ----------------------------------------------------------------------------
//  port group     | handshake                       | payload
//  ---------------+---------------------------------+----------------
//  request in     | start, busy (busy is always low) | char_in
//  result out     | done (one-cycle strobe)          | char_out
//  configuration  | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
//  a request is taken every cycle; its result passes the input register,
//  one table stage per slot and the output register, SLOTS being the
//  smaller of MAX_ROTOR_SLOTS and four
//  reset clears the stage valid bits and loads the default settings
//  nothing stalls: results are strobed out as they leave the last stage
// ----------------------------------------------------------------------------
`default_nettype none

module rotor_substitution_cipher_core
  import rsc_pkg::*;
#(
  parameter int MAX_ROTOR_SLOTS = MAX_ROTOR_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CHAR_W-1:0] char_in,
  output logic                   done,
  output logic      [CHAR_W-1:0] char_out
);

  localparam int SLOTS = (MAX_ROTOR_SLOTS < SLOT_REGS) ? MAX_ROTOR_SLOTS : SLOT_REGS;

  cfg_t            cfg;
  logic [SLOTS:0]  vld;
  stage_t          dat [SLOTS+1];
  stage_t          in_next;
  logic            req_vld;
  stage_t          req_dat;
  logic [CHAR_W-1:0] char_next;

  assign busy = 1'b0;

  rsc_cfg #(
    .MAX_ROTOR_SLOTS(MAX_ROTOR_SLOTS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    in_next.letter = (char_in >= CHAR_A) && (char_in <= CHAR_Z);
    in_next.idx    = LETTER_W'(char_in - CHAR_A);
    in_next.code   = char_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else begin
      req_vld <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    req_dat <= in_next;
  end

  assign vld[0] = req_vld;
  assign dat[0] = req_dat;

  for (genvar k = 0; k < SLOTS; k++) begin : g_slot
    rsc_slot #(
      .STAGE(k)
    ) u_slot (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .in_valid  (vld[k]),
      .in_data   (dat[k]),
      .out_valid (vld[k+1]),
      .out_data  (dat[k+1])
    );
  end

  assign char_next = dat[SLOTS].letter ? (CHAR_W'(dat[SLOTS].idx) + CHAR_A)
                                       : dat[SLOTS].code;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[SLOTS];
    end
  end

  always_ff @(posedge clk) begin
    char_out <= char_next;
  end

endmodule

`default_nettype wire

// ===== rtl/core/rsc_cfg.sv =====
// ----------------------------------------------------------------------------
// rsc_cfg
// Register file behind the APB port; presents normalized settings.
// ----------------------------------------------------------------------------
`default_nettype none

module rsc_cfg
  import rsc_pkg::*;
#(
  parameter int MAX_ROTOR_SLOTS = MAX_ROTOR_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  localparam int SLOTS = (MAX_ROTOR_SLOTS < SLOT_REGS) ? MAX_ROTOR_SLOTS : SLOT_REGS;

  logic [SEL_W-1:0] first_rotor;
  logic [SEL_W-1:0] second_rotor;
  logic [SEL_W-1:0] third_rotor;
  logic [SEL_W-1:0] fourth_rotor;
  logic [CNT_W-1:0] active_rotors;
  logic [ROT_W-1:0] rotation;
  logic             decrypt_mode;

  logic [2:0]       reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_rotor   <= WIRING_MIN;
      second_rotor  <= WIRING_MIN;
      third_rotor   <= WIRING_MIN;
      fourth_rotor  <= WIRING_MIN;
      active_rotors <= '0;
      rotation      <= '0;
      decrypt_mode  <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FIRST_ROTOR:   first_rotor   <= pwdata[SEL_W-1:0];
        REG_SECOND_ROTOR:  second_rotor  <= pwdata[SEL_W-1:0];
        REG_THIRD_ROTOR:   third_rotor   <= pwdata[SEL_W-1:0];
        REG_FOURTH_ROTOR:  fourth_rotor  <= pwdata[SEL_W-1:0];
        REG_ACTIVE_ROTORS: active_rotors <= pwdata[CNT_W-1:0];
        REG_ROTATION:      rotation      <= pwdata[ROT_W-1:0];
        REG_DECRYPT_MODE:  decrypt_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FIRST_ROTOR:   prdata = DATA_W'(first_rotor);
      REG_SECOND_ROTOR:  prdata = DATA_W'(second_rotor);
      REG_THIRD_ROTOR:   prdata = DATA_W'(third_rotor);
      REG_FOURTH_ROTOR:  prdata = DATA_W'(fourth_rotor);
      REG_ACTIVE_ROTORS: prdata = DATA_W'(active_rotors);
      REG_ROTATION:      prdata = DATA_W'(rotation);
      REG_DECRYPT_MODE:  prdata = DATA_W'(decrypt_mode);
      default:           prdata = '0;
    endcase
  end

  function automatic logic [SEL_W-1:0] norm_sel(input logic [SEL_W-1:0] sel);
    return (sel >= WIRING_MIN && sel <= WIRING_MAX) ? sel : WIRING_ID;
  endfunction

  always_comb begin
    cfg.wiring[0] = norm_sel(first_rotor);
    cfg.wiring[1] = norm_sel(second_rotor);
    cfg.wiring[2] = norm_sel(third_rotor);
    cfg.wiring[3] = norm_sel(fourth_rotor);
    cfg.count     = (active_rotors > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : active_rotors;
    // rotation above 25 wraps once
    cfg.rot       = (rotation >= ROT_W'(LETTERS)) ? ROT_W'(rotation - ROT_W'(LETTERS))
                                                  : rotation;
    cfg.decrypt   = decrypt_mode;
  end

endmodule

`default_nettype wire

// ===== rtl/core/rsc_slot.sv =====
// ----------------------------------------------------------------------------
// rsc_slot
// One rotor pipeline stage: rotated table lookup, forward or inverse.
// ----------------------------------------------------------------------------
`default_nettype none

module rsc_slot
  import rsc_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   in_valid,
  input  wire stage_t in_data,
  output logic        out_valid,
  output stage_t      out_data
);

  logic                  active;
  logic [SLOT_IDX_W-1:0] slot_sel;
  logic [SEL_W-1:0]      tab;
  logic [LETTER_W:0]     fwd_diff;
  logic [LETTER_W-1:0]   fwd_pos;
  logic [LETTER_W-1:0]   fwd_val;
  logic [LETTER_W-1:0]   bwd_pos;
  logic [LETTER_W:0]     bwd_sum;
  logic [LETTER_W-1:0]   bwd_val;
  stage_t                data_next;

  always_comb begin
    active   = CNT_W'(STAGE) < cfg.count;
    // decryption walks the active slots from the last one back
    slot_sel = cfg.decrypt ? SLOT_IDX_W'(cfg.count - CNT_W'(STAGE + 1))
                           : SLOT_IDX_W'(STAGE);
    tab      = cfg.wiring[slot_sel];

    fwd_diff = {1'b0, in_data.idx} + LETTERS_W - {1'b0, cfg.rot};
    fwd_pos  = (fwd_diff >= LETTERS_W) ? LETTER_W'(fwd_diff - LETTERS_W)
                                       : LETTER_W'(fwd_diff);
    fwd_val  = wire_out(tab, fwd_pos);

    bwd_pos  = wire_in(tab, in_data.idx);
    bwd_sum  = {1'b0, bwd_pos} + {1'b0, cfg.rot};
    bwd_val  = (bwd_sum >= LETTERS_W) ? LETTER_W'(bwd_sum - LETTERS_W)
                                      : LETTER_W'(bwd_sum);

    data_next = in_data;
    if (in_data.letter && active) begin
      data_next.idx = cfg.decrypt ? bwd_val : fwd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rotor substitution cipher core. Requests are
// pushed through the start/busy port with random idle bursts, and every
// accepted character is run through a local rotor model built from the
// current register shadow. A monitor compares each done strobe against the
// oldest predicted character. Settings are changed over the APB port only
// when the pipeline has drained: a short directed set first, then random
// rotor choices, counts, rotations and directions.
// ----------------------------------------------------------------------------
module testbench;
  import rsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACTIVE_CAP   = (MAX_ROTOR_SLOTS_DEF < SLOT_REGS) ?
                                MAX_ROTOR_SLOTS_DEF : SLOT_REGS;
  localparam int PIPE_SLACK   = ACTIVE_CAP + 4;
  localparam int END_SLACK    = 4 * PIPE_SLACK;
  localparam int RANDOM_ITEMS = 1530;
  localparam int MAX_REPORTS  = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(4 * (int'(REG_DECRYPT_MODE) + 1));

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              start = 1'b0;
  logic              busy;
  logic [CHAR_W-1:0] char_in = '0;
  logic              done;
  logic [CHAR_W-1:0] char_out;

  // register shadow used by the predictor
  logic [SEL_W-1:0]  rotor_sel [SLOT_REGS];
  logic [CNT_W-1:0]  active_cnt;
  logic [ROT_W-1:0]  rotation_amt;
  logic              decrypt_on;

  logic [CHAR_W-1:0] pending_chars[$];
  logic [CHAR_W-1:0] expected_chars[$];

  int idle_pct = 0;
  int idle_left = 0;
  int mismatch_count = 0;
  int requests_taken = 0;
  int letters_taken = 0;
  int phases_run = 1;
  int decrypt_phases = 0;
  int cycle_count = 0;

  rotor_substitution_cipher_core DUT (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .char_in, .done, .char_out
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // letter index at position pos of wiring table tab, table zero is straight through
  function automatic int wiring_letter(int tab, int pos);
    string w;
    case (tab)
      1: w = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
      2: w = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
      3: w = "BDFHJLCPRTXVZNYEIWGAKMUSQO";
      4: w = "ESOVPZJAYQUIRHXLNFTGKDCMWB";
      5: w = "VZBRGITYUPSDNHLXAWMJQOFECK";
      6: w = "JPGVOUMFYQBENHZRDKASXLICTW";
      7: w = "NZJHGRCXMYSWBOUFAIVLPEKQDT";
      8: w = "FKQHTLXOCBJSPDZRAMEWNIUYGV";
      default: w = "ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    endcase
    return int'(w[pos]) - int'(CHAR_A);
  endfunction

  function automatic int slot_table(int s);
    if (rotor_sel[s] >= WIRING_MIN && rotor_sel[s] <= WIRING_MAX) begin
      return int'(rotor_sel[s]);
    end
    return 0;
  endfunction

  function automatic logic [CHAR_W-1:0] cipher_char(logic [CHAR_W-1:0] c);
    int x;
    int n;
    int rot;
    int tab;
    int pos;
    if (c < CHAR_A || c > CHAR_Z) begin
      return c;
    end
    x   = int'(c - CHAR_A);
    n   = (int'(active_cnt) > ACTIVE_CAP) ? ACTIVE_CAP : int'(active_cnt);
    rot = int'(rotation_amt) % LETTERS;
    if (!decrypt_on) begin
      for (int s = 0; s < n; s++) begin
        x = wiring_letter(slot_table(s), (x + LETTERS - rot) % LETTERS);
      end
    end else begin
      // inverse tables, last active slot first
      for (int s = n - 1; s >= 0; s--) begin
        tab = slot_table(s);
        pos = 0;
        for (int i = 0; i < LETTERS; i++) begin
          if (wiring_letter(tab, i) == x) begin
            pos = i;
          end
        end
        x = (pos + rot) % LETTERS;
      end
    end
    return CHAR_A + CHAR_W'(x);
  endfunction

  function automatic logic [CHAR_W-1:0] random_char();
    case ($urandom_range(9))
      0, 1: return CHAR_W'($urandom);
      2: begin
        case ($urandom_range(4))
          0: return CHAR_A - 8'd1;
          1: return CHAR_Z + 8'd1;
          2: return 8'h20;
          3: return 8'h00;
          default: return 8'hFF;
        endcase
      end
      default: return CHAR_A + CHAR_W'($urandom_range(LETTERS - 1));
    endcase
  endfunction

  function automatic logic [SEL_W-1:0] pick_rotor();
    if ($urandom_range(7) == 0) begin
      return SEL_W'($urandom);
    end
    return SEL_W'($urandom_range(int'(WIRING_MIN), int'(WIRING_MAX)));
  endfunction

  // value in the low bits, junk above the field
  function automatic logic [DATA_W-1:0] with_noise(int v, int w);
    return (DATA_W'($urandom) << w) | DATA_W'(v);
  endfunction

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_setting(reg_idx_t idx, logic [DATA_W-1:0] value);
    apb_write(ADDR_W'(4 * int'(idx)), value);
    case (idx)
      REG_FIRST_ROTOR:   rotor_sel[0] = value[SEL_W-1:0];
      REG_SECOND_ROTOR:  rotor_sel[1] = value[SEL_W-1:0];
      REG_THIRD_ROTOR:   rotor_sel[2] = value[SEL_W-1:0];
      REG_FOURTH_ROTOR:  rotor_sel[3] = value[SEL_W-1:0];
      REG_ACTIVE_ROTORS: active_cnt   = value[CNT_W-1:0];
      REG_ROTATION:      rotation_amt = value[ROT_W-1:0];
      REG_DECRYPT_MODE:  decrypt_on   = value[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained(int slack);
    while (pending_chars.size() != 0 || expected_chars.size() != 0) @(negedge clk);
    repeat (slack) @(negedge clk);
  endtask

  task automatic load_settings(logic [SEL_W-1:0] s0, logic [SEL_W-1:0] s1,
                               logic [SEL_W-1:0] s2, logic [SEL_W-1:0] s3,
                               logic [CNT_W-1:0] cnt, logic [ROT_W-1:0] rot,
                               logic dec);
    wait_drained(PIPE_SLACK);
    write_setting(REG_FIRST_ROTOR,   with_noise(s0, SEL_W));
    write_setting(REG_SECOND_ROTOR,  with_noise(s1, SEL_W));
    write_setting(REG_THIRD_ROTOR,   with_noise(s2, SEL_W));
    write_setting(REG_FOURTH_ROTOR,  with_noise(s3, SEL_W));
    write_setting(REG_ACTIVE_ROTORS, with_noise(cnt, CNT_W));
    write_setting(REG_ROTATION,      with_noise(rot, ROT_W));
    write_setting(REG_DECRYPT_MODE,  with_noise(dec, 1));
    phases_run++;
    if (dec) begin
      decrypt_phases++;
    end
    @(negedge clk);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      pending_chars.push_back(s[i]);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_chars.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin : drive_requests
    logic offer;
    offer = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_chars.push_back(cipher_char(char_in));
        requests_taken++;
        if (char_in >= CHAR_A && char_in <= CHAR_Z) begin
          letters_taken++;
        end
        void'(pending_chars.pop_front());
      end
      if (start && busy) begin
        offer = 1'b1;
      end else if (idle_left > 0) begin
        idle_left--;
      end else if (pending_chars.size() != 0) begin
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
          idle_left = $urandom_range(11);
        end else begin
          offer = 1'b1;
        end
      end
      start   <= offer;
      char_in <= offer ? pending_chars[0] : CHAR_W'($urandom);
    end
  end

  // result monitor
  always @(posedge clk) begin : check_results
    logic [CHAR_W-1:0] want;
    if (!rst && done) begin
      if (expected_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result char_out=%02h at cycle %0d", char_out, cycle_count);
        end
      end else begin
        want = expected_chars.pop_front();
        if (char_out !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("char_out mismatch at cycle %0d: expected %02h got %02h",
                     cycle_count, want, char_out);
          end
        end
      end
    end
  end

  initial begin : run_tests
    int total;
    int n;
    logic [CNT_W-1:0] cnt;
    logic [ROT_W-1:0] rot;
    rotor_sel    = '{default: WIRING_MIN};
    active_cnt   = '0;
    rotation_amt = '0;
    decrypt_on   = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // defaults out of reset: no active slots, everything passes
    idle_pct = 30;
    push_text("AZ@[a ` {");
    pending_chars.push_back(8'h00);
    pending_chars.push_back(8'hFF);

    load_settings(4'd1, 4'd2, 4'd3, 4'd4, 3'd4, 5'd0, 1'b0);
    push_text("AZM");
    load_settings(4'd1, 4'd2, 4'd3, 4'd4, 3'd4, 5'd25, 1'b1);
    push_text("AZQ");
    // count above the slot limit and rotation past a full turn
    load_settings(4'd5, 4'd6, 4'd7, 4'd8, 3'd7, 5'd31, 1'b0);
    push_text("AZ");
    // out-of-range selects fall back to straight wiring
    load_settings(4'd0, 4'd9, 4'd15, 4'd8, 3'd3, 5'd13, 1'b1);
    apb_write(UNUSED_ADDR, '1);
    @(negedge clk);
    push_text("BY");
    load_settings(4'd8, 4'd1, 4'd1, 4'd1, 3'd1, 5'd26, 1'b0);
    push_text("AZ");

    total = 0;
    while (total < RANDOM_ITEMS) begin
      cnt = ($urandom_range(5) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(1, 4));
      rot = ($urandom_range(4) == 0) ? ROT_W'($urandom) : ROT_W'($urandom_range(25));
      load_settings(pick_rotor(), pick_rotor(), pick_rotor(), pick_rotor(), cnt, rot,
                    1'($urandom_range(1)));
      if (total >= RANDOM_ITEMS - 200 || $urandom_range(3) == 0) begin
        idle_pct = 0;
      end else begin
        idle_pct = $urandom_range(10, 50);
      end
      n = $urandom_range(20, 80);
      repeat (n) pending_chars.push_back(random_char());
      total += n;
    end

    wait_drained(END_SLACK);
    $display("%0d requests (%0d uppercase) over %0d rotor settings, %0d in decrypt mode",
             requests_taken, letters_taken, phases_run, decrypt_phases);
    $display("%0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
